// ----- src/mlnp_pkg.sv -----
package mlnp_pkg;

   localparam int NOTE_W = 7;
   localparam int VEL_W  = 7;
   localparam int CMD_W  = 2;

   localparam int DEFAULT_STACK_DEPTH = 8;

   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 2'd2;

   // Operation presented to every cell of the note stack in the same cycle.
   typedef struct packed {
      logic              push;
      logic              remove;
      logic              pop;
      logic              clear;
      logic [NOTE_W-1:0] push_note;
      logic [NOTE_W-1:0] note;
   } stack_ctrl_type;

   // What the stack reports back to the voice logic.
   typedef struct packed {
      logic              found;
      logic              empty;
      logic              full;
      logic [NOTE_W-1:0] top_note;
   } stack_status_type;

   // Position of one cell relative to the fill count.
   typedef struct packed {
      logic occupied;
      logic write_slot;
      logic is_top;
   } slot_type;

endpackage

// ----- src/mlnp_cell.sv -----
module mlnp_cell
   import mlnp_pkg::*;
(
   input  logic              clock,
   input  stack_ctrl_type    ctrl,
   input  slot_type          slot,
   input  logic              found_in,
   input  logic [NOTE_W-1:0] top_in,
   input  logic [NOTE_W-1:0] next_note,
   output logic              found_out,
   output logic [NOTE_W-1:0] top_out,
   output logic [NOTE_W-1:0] note
);

   logic [NOTE_W-1:0] note_ff;
   logic [NOTE_W-1:0] note_in;
   logic              match;

   assign match     = slot.occupied && (note_ff == ctrl.note);
   assign found_out = found_in | match;
   assign top_out   = slot.is_top ? note_ff : top_in;
   assign note      = note_ff;

   // A removal closes the gap: every cell at or above the first match
   // takes the word of its upper neighbor.
   always_comb begin
      note_in = note_ff;
      if (ctrl.push && slot.write_slot) begin
         note_in = ctrl.push_note;
      end else if (ctrl.remove && found_out) begin
         note_in = next_note;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

endmodule

// ----- src/mlnp_stack.sv -----
module mlnp_stack
   import mlnp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  stack_ctrl_type   ctrl,
   output stack_status_type status
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [NOTE_W-1:0] notes [STACK_DEPTH];
   logic [STACK_DEPTH:0] found_chain;
   logic [NOTE_W-1:0] top_chain [STACK_DEPTH+1];

   assign found_chain[0] = 1'b0;
   assign top_chain[0]   = '0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      slot_type          slot;
      logic [NOTE_W-1:0] next_note;

      assign slot.occupied   = CW'(i) < count_ff;
      assign slot.write_slot = CW'(i) == count_ff;
      assign slot.is_top     = CW'(i + 1) == count_ff;

      if (i == STACK_DEPTH - 1) begin : g_last
         assign next_note = notes[i];
      end else begin : g_inner
         assign next_note = notes[i+1];
      end

      mlnp_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .slot      (slot),
         .found_in  (found_chain[i]),
         .top_in    (top_chain[i]),
         .next_note (next_note),
         .found_out (found_chain[i+1]),
         .top_out   (top_chain[i+1]),
         .note      (notes[i])
      );
   end

   assign status.found    = found_chain[STACK_DEPTH];
   assign status.empty    = count_ff == '0;
   assign status.full     = count_ff == CW'(STACK_DEPTH);
   assign status.top_note = top_chain[STACK_DEPTH];

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push && !status.full) begin
         count_in = count_ff + CW'(1);
      end else if ((ctrl.remove && status.found) || ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/mono_last_note_priority.sv -----
// Monophonic last-note-priority voice allocator with a legato note stack.
//
// Input channel (req_): one MIDI-style command per word: note on, note off
// or all notes off, with note number and velocity. A note on with zero
// velocity is treated as a note off.
// Result channel (rsp_): exactly one word per command, giving the voice
// after the command: sounding note, active flag, velocity of the last
// started note and the gate start, gate release and pitch change events.
//
// The result word is valid in the cycle after the command is accepted.
// Throughput is one command per cycle unless the receiver stalls; the
// whole update is one pass through the row of stack cells, whose match
// and top-of-stack chains ripple from the bottom cell to the top one.
// If the receiver stalls, the result word is held in the output register
// and req_ready drops until it is taken; no word is lost.
// Reset empties the stack and leaves the voice idle with velocity zero.
module mono_last_note_priority
   import mlnp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [NOTE_W-1:0] req_note,
   input  logic [VEL_W-1:0]  req_velocity,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NOTE_W-1:0] rsp_sounding_note,
   output logic              rsp_active,
   output logic [VEL_W-1:0]  rsp_note_velocity,
   output logic              rsp_gate_start,
   output logic              rsp_gate_release,
   output logic              rsp_pitch_changed
);

   logic              accept;
   logic              is_on;
   logic              is_off;
   logic              is_all;
   logic              hits_current;
   stack_ctrl_type    ctrl;
   stack_status_type  status;

   logic [NOTE_W-1:0] current_ff, current_in;
   logic              valid_ff, valid_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic              start_in, release_in, changed_in;

   logic              rsp_valid_ff;
   logic              start_ff, release_ff, changed_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_on  = (req_command == CMD_NOTE_ON) && (req_velocity != '0);
   assign is_off = ((req_command == CMD_NOTE_ON) && (req_velocity == '0))
                   || (req_command == CMD_NOTE_OFF);
   assign is_all = req_command == CMD_ALL_OFF;

   assign hits_current = valid_ff && (req_note == current_ff);

   assign ctrl.push      = accept && is_on && valid_ff;
   assign ctrl.remove    = accept && is_off;
   assign ctrl.pop       = accept && is_off && !status.found && hits_current
                           && !status.empty;
   assign ctrl.clear     = accept && is_all;
   assign ctrl.push_note = current_ff;
   assign ctrl.note      = req_note;

   mlnp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   always_comb begin
      current_in = current_ff;
      valid_in   = valid_ff;
      vel_in     = vel_ff;
      start_in   = 1'b0;
      release_in = 1'b0;
      changed_in = 1'b0;
      unique if (is_on) begin
         current_in = req_note;
         valid_in   = 1'b1;
         vel_in     = req_velocity;
         start_in   = 1'b1;
         changed_in = 1'b1;
      end else if (is_off) begin
         // A held copy of the note is removed first; only an unmatched
         // note off of the sounding note moves the voice.
         if (!status.found && hits_current) begin
            if (!status.empty) begin
               current_in = status.top_note;
               changed_in = 1'b1;
            end else begin
               current_in = '0;
               valid_in   = 1'b0;
               release_in = 1'b1;
            end
         end
      end else if (is_all) begin
         current_in = '0;
         valid_in   = 1'b0;
         release_in = valid_ff;
      end else begin
         // The unused command code leaves the voice as it is.
         current_in = current_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         valid_ff     <= 1'b0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            current_ff <= current_in;
            valid_ff   <= valid_in;
            vel_ff     <= vel_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff   <= start_in;
         release_ff <= release_in;
         changed_ff <= changed_in;
      end
   end

   // The idle voice always keeps current note zero, so the state registers
   // double as the result fields.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sounding_note = current_ff;
   assign rsp_active        = valid_ff;
   assign rsp_note_velocity = vel_ff;
   assign rsp_gate_start    = start_ff;
   assign rsp_gate_release  = release_ff;
   assign rsp_pitch_changed = changed_ff;

endmodule

// ----- src/mlnp_checker.sv -----
module mlnp_checker
   import mlnp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [NOTE_W-1:0] rsp_sounding_note,
   input logic              rsp_active,
   input logic [VEL_W-1:0]  rsp_note_velocity,
   input logic              rsp_gate_start,
   input logic              rsp_gate_release,
   input logic              rsp_pitch_changed
);

   // A stalled result word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sounding_note)
      && $stable(rsp_note_velocity) && $stable(rsp_gate_start))
      else $error("stalled result word changed");

   // An idle voice reports note zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sounding_note == '0)
      else $error("idle voice shows a nonzero note");

   // A gate start always leaves a sounding voice with the pitch change flag set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gate_start |-> rsp_active && rsp_pitch_changed
      && !rsp_gate_release && rsp_note_velocity != '0)
      else $error("gate start without an active voice");

   // A release always leaves the voice idle and never moves the pitch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gate_release |-> !rsp_active && !rsp_pitch_changed)
      else $error("gate release with an active voice");

endmodule

bind mono_last_note_priority mlnp_checker u_mlnp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_sounding_note (rsp_sounding_note),
   .rsp_active        (rsp_active),
   .rsp_note_velocity (rsp_note_velocity),
   .rsp_gate_start    (rsp_gate_start),
   .rsp_gate_release  (rsp_gate_release),
   .rsp_pitch_changed (rsp_pitch_changed)
);

// ----- verif/tb_mono_last_note_priority.sv -----
`timescale 1ns / 100ps

module tb_mono_last_note_priority;
   import mlnp_pkg::*;

   localparam int HELD_DEPTH = DEFAULT_STACK_DEPTH;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [NOTE_W-1:0] sounding;
      logic              active;
      logic [VEL_W-1:0]  velocity;
      logic              gate_on;
      logic              gate_off;
      logic              pitch_moved;
   } voice_word_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command;
   logic [NOTE_W-1:0] req_note;
   logic [VEL_W-1:0]  req_velocity;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [NOTE_W-1:0] rsp_sounding_note;
   logic              rsp_active;
   logic [VEL_W-1:0]  rsp_note_velocity;
   logic              rsp_gate_start;
   logic              rsp_gate_release;
   logic              rsp_pitch_changed;

   // Predicted voice state.
   logic [NOTE_W-1:0] voice_note;
   logic              voice_on;
   logic [VEL_W-1:0]  voice_vel;
   logic [NOTE_W-1:0] held_stack [HELD_DEPTH];
   int                held_depth;

   voice_word_type expected_voice [$];
   int          mismatch_count;
   int          send_idle_pct;
   int          rsp_stall_pct;

   mono_last_note_priority #(
      .STACK_DEPTH(HELD_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_note(req_note),
      .req_velocity(req_velocity),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sounding_note(rsp_sounding_note),
      .rsp_active(rsp_active),
      .rsp_note_velocity(rsp_note_velocity),
      .rsp_gate_start(rsp_gate_start),
      .rsp_gate_release(rsp_gate_release),
      .rsp_pitch_changed(rsp_pitch_changed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one accepted command to the predicted voice and queues the word it must produce.
   task automatic predict_voice(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note,
                                input logic [VEL_W-1:0] vel);
      voice_word_type w;
      int hit;
      int i;
      w = '0;
      hit = -1;
      if (cmd == CMD_NOTE_ON && vel != 0) begin
         if (voice_on && held_depth < HELD_DEPTH) begin
            held_stack[held_depth] = voice_note;
            held_depth++;
         end
         voice_note = note;
         voice_on = 1'b1;
         voice_vel = vel;
         w.gate_on = 1'b1;
         w.pitch_moved = 1'b1;
      end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
         for (i = 0; i < held_depth; i++) begin
            if (hit < 0 && held_stack[i] == note) hit = i;
         end
         if (hit >= 0) begin
            for (i = hit; i < held_depth - 1; i++) held_stack[i] = held_stack[i + 1];
            held_depth--;
         end else if (voice_on && note == voice_note) begin
            if (held_depth > 0) begin
               held_depth--;
               voice_note = held_stack[held_depth];
               w.pitch_moved = 1'b1;
            end else begin
               voice_on = 1'b0;
               voice_note = '0;
               w.gate_off = 1'b1;
            end
         end
      end else if (cmd == CMD_ALL_OFF) begin
         held_depth = 0;
         w.gate_off = voice_on;
         voice_on = 1'b0;
         voice_note = '0;
      end
      w.sounding = voice_on ? voice_note : '0;
      w.active = voice_on;
      w.velocity = voice_vel;
      expected_voice.push_back(w);
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: voice word %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_voice_word();
      voice_word_type w;
      if (expected_voice.size() == 0) begin
         $display("%0t ns: voice word expected none, got note %0d active %0d", $time,
                  rsp_sounding_note, rsp_active);
         mismatch_count++;
      end else begin
         w = expected_voice.pop_front();
         compare_field("sounding_note", w.sounding, rsp_sounding_note);
         compare_field("active", w.active, rsp_active);
         compare_field("note_velocity", w.velocity, rsp_note_velocity);
         compare_field("gate_start", w.gate_on, rsp_gate_start);
         compare_field("gate_release", w.gate_off, rsp_gate_release);
         compare_field("pitch_changed", w.pitch_moved, rsp_pitch_changed);
      end
   endtask

   // The result word of a command is registered, so it cannot leave in the cycle it is taken;
   // checking before predicting keeps the queue in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_voice_word();
         if (req_valid && req_ready) predict_voice(req_command, req_note, req_velocity);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("mono_last_note_priority: mismatch");
      $finish;
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note,
                            input logic [VEL_W-1:0] vel);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_note <= note;
      req_velocity <= vel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic test_note_extremes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(CMD_NOTE_ON, 7'd0, 7'd127);
      send_word(CMD_NOTE_ON, 7'd127, 7'd1);
      send_word(CMD_UNUSED, 7'd127, 7'd127);
      // Zero velocity releases the sounding note and falls back to the held one.
      send_word(CMD_NOTE_ON, 7'd127, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd0, 7'd0);
      send_word(CMD_ALL_OFF, 7'd0, 7'd0);
      send_word(CMD_NOTE_ON, 7'd5, 7'd64);
      send_word(CMD_ALL_OFF, 7'd127, 7'd127);
   endtask

   task automatic test_stack_overflow();
      int k;
      // Ten starts in a row: the last one finds the stack full and drops the sounding note.
      for (k = 0; k < 10; k++) send_word(CMD_NOTE_ON, 7'(10 + k), 7'(100 - k));
      send_word(CMD_NOTE_OFF, 7'd19, 7'd3);
      send_word(CMD_NOTE_OFF, 7'd12, 7'd0);
      send_word(CMD_ALL_OFF, 7'd0, 7'd0);
   endtask

   task automatic test_held_note_removal();
      send_word(CMD_NOTE_ON, 7'd40, 7'd90);
      send_word(CMD_NOTE_ON, 7'd40, 7'd91);
      send_word(CMD_NOTE_ON, 7'd40, 7'd92);
      // The stack copies go first while the voice keeps sounding.
      send_word(CMD_NOTE_OFF, 7'd40, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd99, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd40, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd40, 7'd0);
   endtask

   // Phrases over a narrow band of notes, so that offs mostly hit held or sounding notes.
   task automatic test_random_phrases(input int words, input int send_pct, input int stall_pct);
      logic [NOTE_W-1:0] band [6];
      int on_weight;
      int pick;
      int base;
      int n;
      int k;
      logic [VEL_W-1:0] vel;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      on_weight = 50;
      for (n = 0; n < words; n++) begin
         if (n % 24 == 0) begin
            base = $urandom_range(122);
            for (k = 0; k < 6; k++) band[k] = 7'(base + k);
            on_weight = $urandom_range(75, 35);
         end
         pick = $urandom_range(99);
         if (pick < on_weight) begin
            vel = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
            send_word(CMD_NOTE_ON, band[$urandom_range(5)], vel);
         end else if (pick < 92) begin
            send_word(CMD_NOTE_OFF, band[$urandom_range(5)], 7'($urandom_range(127)));
         end else if (pick < 95) begin
            send_word(CMD_ALL_OFF, 7'($urandom_range(127)), 7'($urandom_range(127)));
         end else if (pick < 97) begin
            send_word(CMD_UNUSED, 7'($urandom_range(127)), 7'($urandom_range(127)));
         end else begin
            send_word(CMD_W'($urandom_range(3)), 7'($urandom_range(127)),
                      7'($urandom_range(127)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_NOTE_ON;
      req_note = '0;
      req_velocity = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      mismatch_count = 0;
      voice_note = '0;
      voice_on = 1'b0;
      voice_vel = '0;
      held_depth = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_note_extremes();
      test_stack_overflow();
      test_held_note_removal();
      test_random_phrases(200, 0, 0);
      test_random_phrases(200, 85, 0);
      test_random_phrases(200, 0, 85);
      test_random_phrases(200, 30, 30);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_voice.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("mono_last_note_priority: match");
      end else begin
         $display("mono_last_note_priority: mismatch");
      end
      $finish;
   end

endmodule

// ----- mono_last_note_priority.f -----
src/mlnp_pkg.sv
src/mlnp_cell.sv
src/mlnp_stack.sv
src/mono_last_note_priority.sv
src/mlnp_checker.sv
verif/tb_mono_last_note_priority.sv
